// ===== design/abs_pkg.sv =====
`default_nettype none
package abs_pkg;

   // message layout: five 32-bit words, one per lane
   localparam int MAX_BYTES  = 20;
   localparam int LANE_BYTES = 4;
   localparam int LANES      = MAX_BYTES / LANE_BYTES;
   localparam int LANE_W     = 8 * LANE_BYTES;
   localparam int LANE_SUM_W = 10;   // 4 * 255 fits in 10 bits
   localparam int CHECK_W    = 14;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIMEOUT_W-1:0] DEF_TIMEOUT = 16'd15;
   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_PAYLOAD_BYTES = 20;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      REQ_MSG  = 2'd0,
      REQ_ACK  = 2'd1,
      REQ_TICK = 2'd2
   } abs_req_kind_type;

   typedef logic [LANES-1:0][LANE_W-1:0] abs_payload_type;

   typedef struct packed {
      logic push;     // append at tail
      logic rotate;   // replace head entry, advance head
   } abs_queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } abs_queue_sts_type;

endpackage
`default_nettype wire

// ===== design/abs_if.sv =====
`default_nettype none
interface abs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] msg_bytes_lo;
   logic [63:0] msg_bytes_mid;
   logic [31:0] msg_bytes_hi;
   logic        ack_number;

   modport source (output valid, req_type, msg_bytes_lo, msg_bytes_mid, msg_bytes_hi,
                   ack_number, input ready);
   modport sink   (input valid, req_type, msg_bytes_lo, msg_bytes_mid, msg_bytes_hi,
                   ack_number, output ready);
endinterface

interface abs_rsp_if;
   logic               valid;
   logic               ready;
   logic               pkt_seq;
   logic [63:0]        pkt_bytes_lo;
   logic [63:0]        pkt_bytes_mid;
   logic [31:0]        pkt_bytes_hi;
   logic signed [13:0] pkt_checksum;
   logic               is_resend;
   logic               msg_dropped;

   modport source (output valid, pkt_seq, pkt_bytes_lo, pkt_bytes_mid, pkt_bytes_hi,
                   pkt_checksum, is_resend, msg_dropped, input ready);
   modport sink   (input valid, pkt_seq, pkt_bytes_lo, pkt_bytes_mid, pkt_bytes_hi,
                   pkt_checksum, is_resend, msg_dropped, output ready);
endinterface
`default_nettype wire

// ===== design/abs_lane.sv =====
`default_nettype none
module abs_lane
   import abs_pkg::*;
#(
   parameter int LANE_INDEX    = 0,
   parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
   input  wire logic [LANE_W-1:0]     msg_word,
   input  wire logic [LANE_W-1:0]     queued_word,
   input  wire logic                  use_queued,
   output logic      [LANE_W-1:0]     masked_word,
   output logic      [LANE_W-1:0]     sel_word,
   output logic      [LANE_SUM_W-1:0] lane_sum
);

   // zero bytes past the payload length
   always_comb begin
      for (int b = 0; b < LANE_BYTES; b++) begin
         if (LANE_INDEX * LANE_BYTES + b < PAYLOAD_BYTES) begin
            masked_word[8*b +: 8] = msg_word[8*b +: 8];
         end else begin
            masked_word[8*b +: 8] = 8'd0;
         end
      end
   end

   // queued entries are stored already masked
   assign sel_word = use_queued ? queued_word : masked_word;

   // byte sum of the selected word
   always_comb begin
      lane_sum = '0;
      for (int b = 0; b < LANE_BYTES; b++) begin
         lane_sum = lane_sum + LANE_SUM_W'(sel_word[8*b +: 8]);
      end
   end

endmodule
`default_nettype wire

// ===== design/abs_merge.sv =====
`default_nettype none
module abs_merge
   import abs_pkg::*;
(
   input  wire logic [LANES-1:0][LANE_SUM_W-1:0] lane_sums,
   input  wire logic                             seq,
   output logic      [CHECK_W-1:0]               check
);

   // byte sum + seq - 1, wrapped to the checksum width
   always_comb begin
      check = CHECK_W'(seq) - CHECK_W'(1);
      for (int l = 0; l < LANES; l++) begin
         check = check + CHECK_W'(lane_sums[l]);
      end
   end

endmodule
`default_nettype wire

// ===== design/abs_queue.sv =====
`default_nettype none
module abs_queue
   import abs_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire abs_queue_ctl_type ctl,
   input  wire abs_payload_type   wr_data,
   output abs_queue_sts_type      sts,
   output abs_payload_type        head_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(QUEUE_DEPTH);

   abs_payload_type mem [QUEUE_DEPTH];

   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   abs_payload_type head_data_ff;
   logic [AW:0]     tail_sum;
   logic [AW-1:0]   tail;
   logic [AW-1:0]   wr_addr;
   logic            wr_en;

   // tail = head + count, wrapped once
   assign tail_sum = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];

   assign wr_en   = ctl.push | ctl.rotate;
   assign wr_addr = ctl.rotate ? head_ff : tail;

   // pointer and count update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.rotate) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + AW'(1);
      end
      if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // storage; head entry prefetched each cycle, with write forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == head_in)) begin
         head_data_ff <= wr_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign head_data = head_data_ff;
   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == CW'(QUEUE_DEPTH));

endmodule
`default_nettype wire

// ===== design/alternating_bit_sender_unit.sv =====
// Latency: a result is valid in the cycle after the transaction that causes it.
// Throughput: one transaction per cycle; the output register lets a new item in
// while a result is taken in the same cycle. The input stalls only while a result
// waits in the output register and rsp ready is low.
// The checksum is a combinational sum over five byte lanes and a merge adder.
// Reset (synchronous, active high): sender idle, sequence bit 0, timer stopped,
// queue empty, timeout register 15. No clearing pass.
`default_nettype none
module alternating_bit_sender_unit
   import abs_pkg::*;
#(
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   abs_req_if.sink                    req_ch,
   abs_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // control state
   logic                 seq_ff, seq_in;
   logic                 acked_ff, acked_in;
   logic [TIMEOUT_W-1:0] timer_left_ff, timer_left_in;
   logic                 timer_on_ff, timer_on_in;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // held packet
   abs_payload_type      held_payload_ff, held_payload_in;
   logic [CHECK_W-1:0]   held_check_ff, held_check_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_seq_ff, out_seq_in;
   abs_payload_type      out_payload_ff, out_payload_in;
   logic [CHECK_W-1:0]   out_check_ff, out_check_in;
   logic                 out_resend_ff, out_resend_in;
   logic                 out_drop_ff, out_drop_in;

   logic                 accept;
   abs_payload_type      msg_words, msg_masked, sel_payload, queue_head;
   logic [LANES-1:0][LANE_SUM_W-1:0] lane_sums;
   logic [CHECK_W-1:0]   new_check;
   logic [TIMEOUT_W-1:0] start_value;
   abs_queue_ctl_type    q_ctl;
   abs_queue_sts_type    q_sts;
   logic                 csr_wr;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_TIMEOUT) ?
                       {{(CSR_DATA_W-TIMEOUT_W){1'b0}}, timeout_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= DEF_TIMEOUT;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_TIMEOUT)) begin
         timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
      end
   end

   assign start_value = (timeout_ff == '0) ? TIMEOUT_W'(1) : timeout_ff;

   // input handshake
   assign req_ch.ready = ~out_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;

   // message split into lane words
   assign msg_words[0] = req_ch.msg_bytes_lo[31:0];
   assign msg_words[1] = req_ch.msg_bytes_lo[63:32];
   assign msg_words[2] = req_ch.msg_bytes_mid[31:0];
   assign msg_words[3] = req_ch.msg_bytes_mid[63:32];
   assign msg_words[4] = req_ch.msg_bytes_hi;

   // byte lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      abs_lane #(
         .LANE_INDEX    (l),
         .PAYLOAD_BYTES (PAYLOAD_BYTES)
      ) u_lane (
         .msg_word    (msg_words[l]),
         .queued_word (queue_head[l]),
         .use_queued  (~q_sts.empty),
         .masked_word (msg_masked[l]),
         .sel_word    (sel_payload[l]),
         .lane_sum    (lane_sums[l])
      );
   end

   abs_merge u_merge (
      .lane_sums (lane_sums),
      .seq       (seq_ff),
      .check     (new_check)
   );

   abs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .wr_data   (msg_masked),
      .sts       (q_sts),
      .head_data (queue_head)
   );

   // transaction handling
   always_comb begin
      seq_in          = seq_ff;
      acked_in        = acked_ff;
      timer_left_in   = timer_left_ff;
      timer_on_in     = timer_on_ff;
      held_payload_in = held_payload_ff;
      held_check_in   = held_check_ff;
      q_ctl           = '0;
      out_valid_in    = out_valid_ff & ~rsp_ch.ready;
      out_seq_in      = out_seq_ff;
      out_payload_in  = out_payload_ff;
      out_check_in    = out_check_ff;
      out_resend_in   = out_resend_ff;
      out_drop_in     = out_drop_ff;
      if (accept) begin
         case (req_ch.req_type)
            REQ_MSG: begin
               if (acked_ff) begin
                  // idle: send oldest queued message, or this one
                  q_ctl.rotate    = ~q_sts.empty;
                  held_payload_in = sel_payload;
                  held_check_in   = new_check;
                  acked_in        = 1'b0;
                  timer_left_in   = start_value;
                  timer_on_in     = 1'b1;
                  out_valid_in    = 1'b1;
                  out_seq_in      = seq_ff;
                  out_payload_in  = sel_payload;
                  out_check_in    = new_check;
                  out_resend_in   = 1'b0;
                  out_drop_in     = 1'b0;
               end else if (q_sts.full) begin
                  out_valid_in   = 1'b1;
                  out_seq_in     = 1'b0;
                  out_payload_in = '0;
                  out_check_in   = '0;
                  out_resend_in  = 1'b0;
                  out_drop_in    = 1'b1;
               end else begin
                  q_ctl.push = 1'b1;
               end
            end
            REQ_ACK: begin
               if (!acked_ff && (req_ch.ack_number == seq_ff)) begin
                  acked_in      = 1'b1;
                  seq_in        = ~seq_ff;
                  timer_on_in   = 1'b0;
                  timer_left_in = '0;
               end
            end
            REQ_TICK: begin
               if (timer_on_ff) begin
                  if (timer_left_ff > TIMEOUT_W'(1)) begin
                     timer_left_in = timer_left_ff - TIMEOUT_W'(1);
                  end else begin
                     // timeout: resend held packet
                     timer_left_in  = start_value;
                     out_valid_in   = 1'b1;
                     out_seq_in     = seq_ff;
                     out_payload_in = held_payload_ff;
                     out_check_in   = held_check_ff;
                     out_resend_in  = 1'b1;
                     out_drop_in    = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= 1'b0;
         acked_ff      <= 1'b1;
         timer_left_ff <= '0;
         timer_on_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         acked_ff      <= acked_in;
         timer_left_ff <= timer_left_in;
         timer_on_ff   <= timer_on_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_payload_ff <= held_payload_in;
      held_check_ff   <= held_check_in;
      out_seq_ff      <= out_seq_in;
      out_payload_ff  <= out_payload_in;
      out_check_ff    <= out_check_in;
      out_resend_ff   <= out_resend_in;
      out_drop_ff     <= out_drop_in;
   end

   // result channel
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.pkt_seq       = out_seq_ff;
   assign rsp_ch.pkt_bytes_lo  = {out_payload_ff[1], out_payload_ff[0]};
   assign rsp_ch.pkt_bytes_mid = {out_payload_ff[3], out_payload_ff[2]};
   assign rsp_ch.pkt_bytes_hi  = out_payload_ff[4];
   assign rsp_ch.pkt_checksum  = out_check_ff;
   assign rsp_ch.is_resend     = out_resend_ff;
   assign rsp_ch.msg_dropped   = out_drop_ff;

endmodule
`default_nettype wire
